@@ rtl/core/acp_pkg.sv @@
// ----------------------------------------------------------------------------
// acp_pkg - allocation pairing checker package
// Shared constants, operation codes and controller state type.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int DEF_ENTRIES      = 256;
  localparam int DEF_ADDRESS_BITS = 48;

  // result word: seven flags then a nine-bit live count
  localparam int LIVE_COUNT_W = 9;
  localparam int OUT_W        = 16;

  typedef enum logic [1:0] {
    OP_NEW       = 2'd0,
    OP_NEW_ARRAY = 2'd1,
    OP_DEL       = 2'd2,
    OP_DEL_ARRAY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_OUT
  } state_t;

endpackage

@@ rtl/core/allocation_pairing_checker.sv @@
// ----------------------------------------------------------------------------
// allocation_pairing_checker - live allocation tracker with pairing checks
// A null address is answered the cycle after it is accepted; any other word
// is answered after a full scan of the table memory through its single read
// port in ST_SCAN, then ST_RESOLVE, then ST_OUT, which presents the result.
// One word in flight; the next word is taken the cycle after the result
// leaves.
// Reset: a clearing pass writes every entry free; no input word is accepted
// until it ends.
// ----------------------------------------------------------------------------
module allocation_pairing_checker #(
  parameter int ENTRIES      = acp_pkg::DEF_ENTRIES,
  parameter int ADDRESS_BITS = acp_pkg::DEF_ADDRESS_BITS,
  localparam int IN_W        = ((ADDRESS_BITS + 50 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // address, size[31:0], size_given, align[15:0], align_given, zero pad
  input  logic [IN_W-1:0]          s_axis_tdata,
  // op[1:0]
  input  logic [1:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // ignored, double_alloc, unknown_free, wrong_kind, wrong_size, wrong_align,
  // table_full, live_count[8:0]
  output logic [acp_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LIVE_W = $clog2(ENTRIES + 1);
  // entry layout, low bit up: align, size, is_array, address, valid
  localparam int ENT_W  = ADDRESS_BITS + 50;
  localparam int A_LO   = 49;
  localparam int V_BIT  = ADDRESS_BITS + 49;

  acp_pkg::state_t state, state_next;

  // latched input word
  logic [1:0]              op;
  logic [ADDRESS_BITS-1:0] address;
  logic [31:0]             size;
  logic                    size_given;
  logic [15:0]             align;
  logic                    align_given;

  // scan bookkeeping
  logic [IDX_W:0]   issue_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] clr_cnt;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_arr;
  logic [31:0]      hit_size;
  logic [15:0]      hit_align;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [LIVE_W-1:0] live;

  // result register
  logic [6:0] flags;

  // memory ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [ENT_W-1:0] rd_data, wr_data;

  logic in_acc, out_acc, is_alloc, is_arr, ent_valid, ent_match, last_cmp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign is_alloc = !op[1];
  assign is_arr   = op[0];

  assign ent_valid = rd_data[V_BIT];
  assign ent_match = ent_valid && (rd_data[V_BIT-1:A_LO] == address);
  assign last_cmp  = cmp_vld && (cmp_idx == IDX_W'(ENTRIES - 1));

  acp_table #(.ENTRIES(ENTRIES), .WIDTH(ENT_W)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      acp_pkg::ST_CLEAR: begin
        if (clr_cnt == IDX_W'(ENTRIES - 1)) state_next = acp_pkg::ST_IDLE;
      end
      acp_pkg::ST_IDLE: begin
        if (in_acc) begin
          // null address skips the table entirely
          if (s_axis_tdata[ADDRESS_BITS-1:0] == '0) state_next = acp_pkg::ST_OUT;
          else state_next = acp_pkg::ST_SCAN;
        end
      end
      acp_pkg::ST_SCAN: begin
        if (last_cmp) state_next = acp_pkg::ST_RESOLVE;
      end
      acp_pkg::ST_RESOLVE: state_next = acp_pkg::ST_OUT;
      acp_pkg::ST_OUT: begin
        if (m_axis_tready) state_next = acp_pkg::ST_IDLE;
      end
      default: state_next = acp_pkg::ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_en   = 1'b0;
    rd_idx  = issue_cnt[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_idx  = clr_cnt;
    wr_data = '0;
    unique case (state)
      acp_pkg::ST_CLEAR: wr_en = 1'b1;
      acp_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      acp_pkg::ST_SCAN:  rd_en = (issue_cnt < (IDX_W+1)'(ENTRIES));
      acp_pkg::ST_RESOLVE: begin
        if (is_alloc) begin
          // insert into the lowest free entry found
          wr_en   = !hit && free_found;
          wr_idx  = free_idx;
          wr_data = {1'b1, address, is_arr,
                     size_given ? size : 32'd0, align_given ? align : 16'd0};
        end else begin
          // drop the matched entry
          wr_en   = hit;
          wr_idx  = hit_idx;
          wr_data = '0;
        end
      end
      acp_pkg::ST_OUT: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {acp_pkg::LIVE_COUNT_W'(live), flags};

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= acp_pkg::ST_CLEAR;
      clr_cnt <= '0;
      live    <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (state == acp_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      cmp_vld <= rd_en;
      if (state == acp_pkg::ST_RESOLVE) begin
        if (is_alloc && !hit && free_found) live <= live + 1'b1;
        else if (!is_alloc && hit && live != '0) live <= live - 1'b1;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (in_acc) begin
      op          <= s_axis_tuser;
      address     <= s_axis_tdata[ADDRESS_BITS-1:0];
      size        <= s_axis_tdata[ADDRESS_BITS+31:ADDRESS_BITS];
      size_given  <= s_axis_tdata[ADDRESS_BITS+32];
      align       <= s_axis_tdata[ADDRESS_BITS+48:ADDRESS_BITS+33];
      align_given <= s_axis_tdata[ADDRESS_BITS+49];
      issue_cnt   <= '0;
      hit         <= 1'b0;
      free_found  <= 1'b0;
      flags       <= 7'b000_0001;   // ignored; overwritten after a scan
    end
    if (rd_en) issue_cnt <= issue_cnt + 1'b1;
    if (state == acp_pkg::ST_SCAN && cmp_vld) begin
      if (ent_match) begin
        hit       <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_arr   <= rd_data[48];
        hit_size  <= rd_data[47:16];
        hit_align <= rd_data[15:0];
      end
      if (!ent_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    if (state == acp_pkg::ST_RESOLVE) begin
      // high bit down: table_full, wrong_align, wrong_size, wrong_kind,
      // unknown_free, double_alloc, ignored
      if (is_alloc) begin
        flags <= {!hit && !free_found, 4'b0000, hit, 1'b0};
      end else begin
        flags <= {1'b0,
                  hit && align_given && (hit_align != align),
                  hit && size_given && (hit_size != size),
                  hit && (hit_arr != is_arr),
                  !hit, 2'b00};
      end
    end
  end

  // the live count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) live <= LIVE_W'(ENTRIES))
    else $error("live count above table depth");

  // a completed result returns to idle next cycle
  assert property (@(posedge clk) disable iff (rst) out_acc |=> s_axis_tready)
    else $error("not idle after result taken");

  // the table is never written while idle or holding a result
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tready || m_axis_tvalid) |-> !wr_en)
    else $error("table write outside clear or resolve");

  // at most one flag describes an event's table outcome
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0({flags[0], flags[1], flags[2], flags[6]}))
    else $error("conflicting outcome flags");

endmodule

@@ rtl/core/acp_table.sv @@
// ----------------------------------------------------------------------------
// acp_table - allocation table storage
// Single-port-write, single-port-read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module acp_table #(
  parameter int ENTRIES = acp_pkg::DEF_ENTRIES,
  parameter int WIDTH   = 98
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_idx,
  output logic [WIDTH-1:0]           rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_idx,
  input  logic [WIDTH-1:0]           wr_data
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule
